[design/assert_macros.svh]
// -----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the RTL. Both sample on clk_i and are
// switched off while rst_ni is low.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define RCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must never be seen at a clock edge.
`define RCD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[design/rcd_pkg.sv]
// -----------------------------------------------------------------------------
// rcd_pkg
// Shared constants, register codes and types of the remote frame decoder.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcd_pkg;

  localparam int unsigned FRAME_BYTES = 18;
  // Bytes held in the chain; the final byte of a frame is taken straight from the input.
  localparam int unsigned CHAIN_CELLS = FRAME_BYTES - 1;
  localparam int unsigned CNT_W       = 5;
  localparam logic [CNT_W-1:0] CNT_FRAME = CNT_W'(FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_SAT   = CNT_W'(FRAME_BYTES + 1);

  localparam int unsigned STICK_W = 11;
  localparam int unsigned VAL_W   = 12;
  localparam logic signed [VAL_W-1:0] WHEEL_FORCE_ZERO = -12'sd1024;
  localparam logic [1:0] SWITCH_NONE = 2'b00;

  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  localparam logic [STICK_W-1:0] RST_CHANNEL_OFFSET = 11'd1024;
  localparam logic [STICK_W-1:0] RST_DEADBAND       = 11'd10;
  localparam logic [STICK_W-1:0] RST_ERROR_LIMIT    = 11'd660;
  localparam logic [15:0]        RST_OFFLINE_TICKS  = 16'd100;

  typedef enum logic [1:0] {
    CFG_CHANNEL_OFFSET = 2'd0,
    CFG_DEADBAND       = 2'd1,
    CFG_ERROR_LIMIT    = 2'd2,
    CFG_OFFLINE_TICKS  = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    LINK_CONNECTED = 2'd0,
    LINK_ERROR     = 2'd1,
    LINK_LOST      = 2'd2
  } link_status_e;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_TICK = 1'b1
  } action_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] right_x;
    logic signed [VAL_W-1:0] right_y;
    logic signed [VAL_W-1:0] left_x;
    logic signed [VAL_W-1:0] left_y;
    logic signed [VAL_W-1:0] wheel;
    logic [3:0]              switches;
    logic signed [15:0]      mouse_x;
    logic signed [15:0]      mouse_y;
    logic signed [15:0]      mouse_z;
    logic [15:0]             mouse_buttons;
    logic [15:0]             key_mask;
  } rcd_values_t;

  // Settings handed to each stick unit.
  typedef struct packed {
    logic [STICK_W-1:0] offset;
    logic [STICK_W-1:0] deadband;
    logic [STICK_W-1:0] limit;
  } rcd_stick_cfg_t;

endpackage

`default_nettype wire

[design/rcd_byte_cell.sv]
// -----------------------------------------------------------------------------
// rcd_byte_cell
// One stage of the receive byte chain: takes its neighbor's byte on a shift.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcd_byte_cell import rcd_pkg::*; (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  output logic [7:0] byte_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

[design/rcd_stick.sv]
// -----------------------------------------------------------------------------
// rcd_stick
// Offset removal, deadband, wheel fix-up and range check for one stick.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcd_stick import rcd_pkg::*; (
  input  logic [STICK_W-1:0]       raw_i,
  input  rcd_stick_cfg_t           cfg_i,
  input  logic                     dead_en_i,
  input  logic                     wheel_en_i,
  output logic signed [VAL_W-1:0]  value_o,
  output logic                     err_o
);

  logic signed [VAL_W-1:0] diff;
  logic [VAL_W-1:0]        mag_full;
  logic [STICK_W-1:0]      mag;
  logic                    zero_out;

  assign diff     = $signed({1'b0, raw_i}) - $signed({1'b0, cfg_i.offset});
  // The difference stays within +/-2047, so the magnitude fits in 11 bits.
  assign mag_full = diff[VAL_W-1] ? VAL_W'(-diff) : VAL_W'(diff);
  assign mag      = mag_full[STICK_W-1:0];

  assign zero_out = (dead_en_i && (mag <= cfg_i.deadband)) ||
                    (wheel_en_i && (diff == WHEEL_FORCE_ZERO));

  assign value_o = zero_out ? '0 : diff;
  assign err_o   = !zero_out && (mag > cfg_i.limit);

endmodule

`default_nettype wire

[design/rc_receiver_frame_decoder.sv]
// -----------------------------------------------------------------------------
// rc_receiver_frame_decoder
// Decodes remote receiver frames from a byte stream mixed with time ticks.
// -----------------------------------------------------------------------------
// Result: registered, and valid in the cycle after the beat of the final frame
// byte or of the tick that causes it.
// Throughput: one beat (byte or tick) per cycle while in_stall_o is low; the final byte
// is decoded in its own cycle against the 17-cell byte chain.
// Reset: control, counters, settings and held values clear at once; the
// byte chain holds no reset value and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rc_receiver_frame_decoder import rcd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,

  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [15:0]               cfg_data_i,

  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      action_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      last_byte_i,

  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VAL_W-1:0]   right_x_o,
  output logic signed [VAL_W-1:0]   right_y_o,
  output logic signed [VAL_W-1:0]   left_x_o,
  output logic signed [VAL_W-1:0]   left_y_o,
  output logic signed [VAL_W-1:0]   wheel_o,
  output logic [3:0]                switches_o,
  output logic signed [15:0]        mouse_x_o,
  output logic signed [15:0]        mouse_y_o,
  output logic signed [15:0]        mouse_z_o,
  output logic [15:0]               mouse_buttons_o,
  output logic [15:0]               key_mask_o,
  output logic [1:0]                link_status_o
);

  // ---------------------------------------------------------------------------
  // Settings
  // ---------------------------------------------------------------------------
  logic [STICK_W-1:0] offset_q, deadband_q, limit_q;
  logic [15:0]        offline_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= RST_CHANNEL_OFFSET;
      deadband_q <= RST_DEADBAND;
      limit_q    <= RST_ERROR_LIMIT;
      offline_q  <= RST_OFFLINE_TICKS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_CHANNEL_OFFSET: offset_q   <= cfg_data_i[STICK_W-1:0];
        CFG_DEADBAND:       deadband_q <= cfg_data_i[STICK_W-1:0];
        CFG_ERROR_LIMIT:    limit_q    <= cfg_data_i[STICK_W-1:0];
        CFG_OFFLINE_TICKS:  offline_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic in_accept, out_take;
  logic byte_beat, tick_beat;

  // A new beat may load the output register only once it is free or leaving.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign byte_beat  = in_accept && (action_e'(action_i) == ACT_BYTE);
  assign tick_beat  = in_accept && (action_e'(action_i) == ACT_TICK);

  // ---------------------------------------------------------------------------
  // Byte chain: cell 0 holds the newest byte.
  // ---------------------------------------------------------------------------
  logic [7:0] cell_byte [CHAIN_CELLS];
  logic [7:0] fb [FRAME_BYTES];

  for (genvar c = 0; c < CHAIN_CELLS; c++) begin : g_chain
    rcd_byte_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (byte_beat),
      .byte_i  ((c == 0) ? data_byte_i : cell_byte[(c == 0) ? 0 : c - 1]),
      .byte_o  (cell_byte[c])
    );
  end

  // Frame byte k sits CHAIN_CELLS-1-k cells back; the last one is on the input.
  for (genvar k = 0; k < CHAIN_CELLS; k++) begin : g_fb
    assign fb[k] = cell_byte[CHAIN_CELLS-1-k];
  end
  assign fb[FRAME_BYTES-1] = data_byte_i;

  // ---------------------------------------------------------------------------
  // Byte count and frame detection
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] count_q, count_inc;
  logic             frame_end;

  assign count_inc = (count_q < CNT_SAT) ? count_q + 1'b1 : count_q;
  assign frame_end = byte_beat && last_byte_i && (count_inc == CNT_FRAME);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (byte_beat) begin
      count_q <= last_byte_i ? '0 : count_inc;
    end
  end

  // ---------------------------------------------------------------------------
  // Stick decode
  // ---------------------------------------------------------------------------
  rcd_stick_cfg_t          stick_cfg;
  logic [STICK_W-1:0]      raw [5];
  logic signed [VAL_W-1:0] stick_val [5];
  logic [4:0]              stick_err;
  logic [1:0]              sw_left, sw_right;
  logic                    frame_err;

  assign stick_cfg = '{offset: offset_q, deadband: deadband_q, limit: limit_q};

  assign raw[0] = {fb[1][2:0], fb[0]};
  assign raw[1] = {fb[2][5:0], fb[1][7:3]};
  assign raw[2] = {fb[4][0], fb[3], fb[2][7:6]};
  assign raw[3] = {fb[5][3:0], fb[4][7:1]};
  assign raw[4] = {fb[17][2:0], fb[16]};

  for (genvar s = 0; s < 5; s++) begin : g_stick
    rcd_stick u_stick (
      .raw_i      (raw[s]),
      .cfg_i      (stick_cfg),
      .dead_en_i  ((s == 2) || (s == 3)),
      .wheel_en_i (s == 4),
      .value_o    (stick_val[s]),
      .err_o      (stick_err[s])
    );
  end

  assign sw_left   = fb[5][7:6];
  assign sw_right  = fb[5][5:4];
  assign frame_err = (|stick_err) || (sw_left == SWITCH_NONE) || (sw_right == SWITCH_NONE);

  rcd_values_t frame_vals;

  always_comb begin
    frame_vals = '{
      right_x:       stick_val[0],
      right_y:       stick_val[1],
      left_x:        stick_val[2],
      left_y:        stick_val[3],
      wheel:         stick_val[4],
      switches:      {sw_left, sw_right},
      mouse_x:       {fb[7], fb[6]},
      mouse_y:       {fb[9], fb[8]},
      mouse_z:       {fb[11], fb[10]},
      mouse_buttons: {fb[13], fb[12]},
      key_mask:      {fb[15], fb[14]}
    };
    if (frame_err) begin
      frame_vals = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Tick timer and link-lost detection
  // ---------------------------------------------------------------------------
  logic [15:0] ticks_q, ticks_inc;
  logic        lost_sent_q;
  logic        lost_fire;

  assign ticks_inc = (ticks_q != TICKS_MAX) ? ticks_q + 16'd1 : ticks_q;
  assign lost_fire = tick_beat && (ticks_inc > offline_q) && !lost_sent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q     <= '0;
      lost_sent_q <= 1'b0;
    end else if (frame_end) begin
      ticks_q     <= '0;
      lost_sent_q <= 1'b0;
    end else if (tick_beat) begin
      ticks_q <= ticks_inc;
      if (lost_fire) begin
        lost_sent_q <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Held values and output register
  // ---------------------------------------------------------------------------
  rcd_values_t  held_q;
  rcd_values_t  out_vals_q;
  link_status_e out_status_q;
  link_status_e new_status;
  logic         load;

  assign load       = frame_end || lost_fire;
  assign new_status = lost_fire ? LINK_LOST : (frame_err ? LINK_ERROR : LINK_CONNECTED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (frame_end) begin
      held_q <= frame_vals;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_vals_q   <= lost_fire ? held_q : frame_vals;
      out_status_q <= new_status;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign right_x_o       = out_vals_q.right_x;
  assign right_y_o       = out_vals_q.right_y;
  assign left_x_o        = out_vals_q.left_x;
  assign left_y_o        = out_vals_q.left_y;
  assign wheel_o         = out_vals_q.wheel;
  assign switches_o      = out_vals_q.switches;
  assign mouse_x_o       = out_vals_q.mouse_x;
  assign mouse_y_o       = out_vals_q.mouse_y;
  assign mouse_z_o       = out_vals_q.mouse_z;
  assign mouse_buttons_o = out_vals_q.mouse_buttons;
  assign key_mask_o      = out_vals_q.key_mask;
  assign link_status_o   = out_status_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RCD_NEVER(a_no_overwrite, load && out_valid_q && out_stall_i,
             "result loaded over a stalled result")
  `RCD_NEVER(a_count_range, count_q > CNT_SAT, "byte count beyond saturation")
  `RCD_ASSERT(a_frame_clears_timer, frame_end |=> (ticks_q == '0) && !lost_sent_q,
              "frame did not restart the tick timer")
  `RCD_ASSERT(a_lost_once, lost_fire |=> lost_sent_q && out_valid_q,
              "link-lost result not recorded")

endmodule

`default_nettype wire
